FILE: rtl/tamv_pkg.sv
// Shared constants and types for the three-axis running mean/variance block.
// No dependencies; imported by tamv_div and three_axis_running_mean_variance.
package tamv_pkg;

  localparam int SAMPLE_BITS = 13;              // raw sample width, signed
  localparam int MAX_SAMPLES = 65535;           // count ceiling per window
  localparam int AXES        = 3;
  localparam int AX_W        = $clog2(AXES);
  localparam int CNT_W       = 16;              // sample count / divisor width
  localparam int SQ_W        = 48;              // squared-deviation sum width
  localparam int VAR_W       = 26;              // reported variance width
  localparam int DELTA_W     = SAMPLE_BITS + 1; // sample minus mean
  localparam int PROD_W      = 2 * DELTA_W;     // delta times delta2
  localparam int STEP_W      = $clog2(SQ_W + 1);

  // Input operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLOSE  = 1'b1;

  // Divider request and status
  typedef struct packed {
    logic              start;
    logic [SQ_W-1:0]   dividend;
    logic [CNT_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [SQ_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/tamv_div.sv
// Shared restoring divider: one quotient bit per cycle, MSB first.
// Depends on tamv_pkg (widths, div_req_t, div_rsp_t).
module tamv_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tamv_pkg::div_req_t req,
  output tamv_pkg::div_rsp_t rsp
);
  import tamv_pkg::*;

  logic [SQ_W-1:0]   dvd_r;
  logic [SQ_W-1:0]   quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;
  logic           fits;

  assign trial = {rem_r, dvd_r[SQ_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[SQ_W-2:0], 1'b0};
      quo_r <= {quo_r[SQ_W-2:0], fits};
      rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/three_axis_running_mean_variance.sv
// Three-axis running mean and variance (integer Welford update per axis).
// Depends on tamv_pkg and tamv_div (shared iterative divider).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  in_     | in  | in_valid / in_stall  | op, sample_x, sample_y, sample_z
//  out_    | out | out_valid / out_stall| mean_xyz, variance_xyz, window_count, sat
//
//  Work per input transfer, one axis after another:
//    sample: per axis a launch of delta / n, the wait for its quotient and the
//      mean update, then a multiply and an accumulate into the sum.
//    close with at least two samples: per axis a launch of sum / (n - 1) and
//      the wait for its quotient, then report; else report alone.
//  A sample arriving at full count only sets the flag.
//  Reset: synchronous, active low; clears count, means, sums and the flag.
//  in_stall is high while an item is in work; a held result does not block
//    samples, only a later close waits for out_ to free up.
module three_axis_running_mean_variance (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic signed [tamv_pkg::SAMPLE_BITS-1:0] in_sample_x,
  input  logic signed [tamv_pkg::SAMPLE_BITS-1:0] in_sample_y,
  input  logic signed [tamv_pkg::SAMPLE_BITS-1:0] in_sample_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tamv_pkg::SAMPLE_BITS-1:0] out_mean_x,
  output logic signed [tamv_pkg::SAMPLE_BITS-1:0] out_mean_y,
  output logic signed [tamv_pkg::SAMPLE_BITS-1:0] out_mean_z,
  output logic        [tamv_pkg::VAR_W-1:0]       out_variance_x,
  output logic        [tamv_pkg::VAR_W-1:0]       out_variance_y,
  output logic        [tamv_pkg::VAR_W-1:0]       out_variance_z,
  output logic        [tamv_pkg::CNT_W-1:0]       out_window_count,
  output logic                                out_count_saturated
);
  import tamv_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MSTART = 8'b0000_0010,  // launch delta / n
    S_MDIV   = 8'b0000_0100,  // wait for quotient, update mean
    S_MUL    = 8'b0000_1000,  // delta * delta2
    S_ACC    = 8'b0001_0000,  // saturating add into the sum
    S_VSTART = 8'b0010_0000,  // launch sum / (n - 1)
    S_VDIV   = 8'b0100_0000,  // wait for variance quotient
    S_REPORT = 8'b1000_0000   // load the output register, clear window
  } state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  state_t state_r, state_nxt;

  // window state
  logic [CNT_W-1:0]               cnt_r;
  logic                           sat_r;
  logic signed [SAMPLE_BITS-1:0]  mean_r [AXES];
  logic [SQ_W-1:0]                sq_r   [AXES];

  // per-item work registers
  logic signed [SAMPLE_BITS-1:0]  smp_r  [AXES];
  logic [AX_W-1:0]                ax_r;
  logic signed [DELTA_W-1:0]      delta_r;
  logic signed [DELTA_W-1:0]      delta2_r;
  logic                           neg_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic [VAR_W-1:0]               var_r  [AXES];

  // output register
  logic                           out_valid_r;
  logic signed [SAMPLE_BITS-1:0]  out_mean_r [AXES];
  logic [VAR_W-1:0]               out_var_r  [AXES];
  logic [CNT_W-1:0]               out_cnt_r;
  logic                           out_sat_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tamv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  logic in_xfer;
  logic out_free;
  logic last_ax;
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_ax  = (ax_r == AX_W'(AXES - 1));

  // Welford arithmetic on the selected axis
  logic signed [SAMPLE_BITS-1:0] sel_s, sel_m, mean_new;
  logic signed [DELTA_W-1:0]     delta, qsgn, mean_sum, delta2;
  logic [DELTA_W-1:0]            delta_mag, quo;
  logic [PROD_W-1:0]             add_val;
  logic [SQ_W:0]                 sq_sum;
  logic [SQ_W-1:0]               sq_new;
  logic [SQ_W-1:0]               vq;
  logic [VAR_W-1:0]              var_sat;

  assign sel_s     = smp_r[ax_r];
  assign sel_m     = mean_r[ax_r];
  assign delta     = {sel_s[SAMPLE_BITS-1], sel_s} - {sel_m[SAMPLE_BITS-1], sel_m};
  assign delta_mag = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
  assign quo       = div_rsp.quotient[DELTA_W-1:0];
  assign qsgn      = neg_r ? -$signed(quo) : $signed(quo);
  // truncating divide keeps the new mean between old mean and sample
  assign mean_sum  = {sel_m[SAMPLE_BITS-1], sel_m} + qsgn;
  assign mean_new  = mean_sum[SAMPLE_BITS-1:0];
  assign delta2    = {sel_s[SAMPLE_BITS-1], sel_s} - {mean_new[SAMPLE_BITS-1], mean_new};
  // only positive products are added
  assign add_val   = (prod_r > 0) ? PROD_W'(prod_r) : '0;
  assign sq_sum    = {1'b0, sq_r[ax_r]} + (SQ_W + 1)'(add_val);
  assign sq_new    = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
  assign vq        = div_rsp.quotient;
  assign var_sat   = (|vq[SQ_W-1:VAR_W]) ? '1 : vq[VAR_W-1:0];

  // divider launch
  always_comb begin
    div_req = '0;
    if (state_r == S_MSTART) begin
      div_req.start    = 1'b1;
      div_req.dividend = {delta_mag, (SQ_W - DELTA_W)'(0)};
      div_req.divisor  = cnt_r;
      div_req.steps    = STEP_W'(DELTA_W);
    end else if (state_r == S_VSTART) begin
      div_req.start    = 1'b1;
      div_req.dividend = sq_r[ax_r];
      div_req.divisor  = cnt_r - 1'b1;
      div_req.steps    = STEP_W'(SQ_W);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_CLOSE) begin
            state_nxt = (cnt_r >= CNT_W'(2)) ? S_VSTART : S_REPORT;
          end else if (cnt_r != CNT_MAX) begin
            state_nxt = S_MSTART;
          end
        end
      end
      S_MSTART: state_nxt = S_MDIV;
      S_MDIV:   if (div_rsp.done) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_ACC;
      S_ACC:    state_nxt = last_ax ? S_IDLE : S_MSTART;
      S_VSTART: state_nxt = S_VDIV;
      S_VDIV: begin
        if (div_rsp.done) state_nxt = last_ax ? S_REPORT : S_VSTART;
      end
      S_REPORT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        mean_r[a] <= '0;
        sq_r[a]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // a new report replaces a taken one in the same cycle
      if (state_r == S_REPORT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                 out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          ax_r <= '0;
          if (in_xfer && in_op == OP_SAMPLE) begin
            if (cnt_r == CNT_MAX) sat_r <= 1'b1;
            else                  cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MDIV: if (div_rsp.done) mean_r[ax_r] <= mean_new;
        S_ACC: begin
          sq_r[ax_r] <= sq_new;
          ax_r       <= ax_r + 1'b1;
        end
        S_VDIV: if (div_rsp.done) ax_r <= ax_r + 1'b1;
        S_REPORT: begin
          if (out_free) begin
            cnt_r <= '0;
            sat_r <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
              mean_r[a] <= '0;
              sq_r[a]   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smp_r[0] <= in_sample_x;
      smp_r[1] <= in_sample_y;
      smp_r[2] <= in_sample_z;
      if (in_op == OP_CLOSE) begin
        for (int a = 0; a < AXES; a++) var_r[a] <= '0;
      end
    end
    if (state_r == S_MSTART) begin
      delta_r <= delta;
      neg_r   <= delta[DELTA_W-1];
    end
    if (state_r == S_MDIV && div_rsp.done) delta2_r <= delta2;
    if (state_r == S_MUL)                  prod_r   <= delta_r * delta2_r;
    if (state_r == S_VDIV && div_rsp.done) var_r[ax_r] <= var_sat;
    if (state_r == S_REPORT && out_free) begin
      for (int a = 0; a < AXES; a++) begin
        out_mean_r[a] <= mean_r[a];
        out_var_r[a]  <= var_r[a];
      end
      out_cnt_r <= cnt_r;
      out_sat_r <= sat_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mean_x          = out_mean_r[0];
  assign out_mean_y          = out_mean_r[1];
  assign out_mean_z          = out_mean_r[2];
  assign out_variance_x      = out_var_r[0];
  assign out_variance_y      = out_var_r[1];
  assign out_variance_z      = out_var_r[2];
  assign out_window_count    = out_cnt_r;
  assign out_count_saturated = out_sat_r;

  // checks
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (div_rsp.busy || div_rsp.done) |-> (state_r == S_MDIV || state_r == S_VDIV))
    else $error("divider active outside a divide state");

  a_report_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_REPORT))
    else $error("result raised outside report");

  a_small_var: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_window_count < CNT_W'(2)) |->
      (out_variance_x == '0 && out_variance_y == '0 && out_variance_z == '0))
    else $error("nonzero variance with fewer than two samples");

  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_window_count == '0) |->
      (out_mean_x == '0 && out_mean_y == '0 && out_mean_z == '0))
    else $error("nonzero mean for an empty window");

endmodule
